/* sv/lod_select_hysteresis_macros.svh */
// Assertion macros shared by the checker of the level-of-detail selector.
`ifndef LOD_SELECT_HYSTERESIS_MACROS_SVH
`define LOD_SELECT_HYSTERESIS_MACROS_SVH

// Checks the consequent in the cycle after the antecedent, outside reset.
`define LSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lod_select_hysteresis: next-cycle check failed");

// Checks the consequent in the cycle after reset is seen high.
`define LSH_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("lod_select_hysteresis: post-reset check failed");

`endif

/* sv/lsh_pkg.sv */
`default_nettype none

package lsh_pkg;

  localparam int IDX_W     = 10;
  localparam int DIST_W    = 24;
  localparam int LVL_OUT_W = 3;
  localparam int FRAC_W    = 8;
  localparam int CNT_W     = 4;
  // Spacing can reach 2.5 times a 24-bit world size.
  localparam int SPACE_W   = 26;
  localparam int STEP_W    = 5;
  localparam int HYST_STEPS = 8;

  localparam logic [DIST_W-1:0] MIN_SPACING = 24'd20480;
  localparam logic [FRAC_W-1:0] HYST_CAP    = 8'd230;

  localparam logic [DIST_W-1:0] RST_DISTANCE_SCALE = 24'd20480;
  localparam logic [CNT_W-1:0]  RST_LEVEL_COUNT    = 4'd4;
  localparam logic [FRAC_W-1:0] RST_HYST_FRACTION  = 8'd26;

  typedef enum logic [2:0] {
    REG_DISTANCE_SCALE = 3'd0,
    REG_WORLD_SIZE_X   = 3'd1,
    REG_WORLD_SIZE_Z   = 3'd2,
    REG_LEVEL_COUNT    = 3'd3,
    REG_HYST_FRACTION  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_scale;
    logic [DIST_W-1:0] world_size_x;
    logic [DIST_W-1:0] world_size_z;
    logic [CNT_W-1:0]  level_count;
    logic [FRAC_W-1:0] hysteresis_fraction;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_SPAN,
    S_HYST,
    S_MULT,
    S_CHK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/lod_select_hysteresis.sv */
// Distance-based level-of-detail selector with hysteresis. Each input beat names a chunk
// and its camera distance; the block reads that chunk's stored level, derives the level
// spacing and hysteresis from the configuration, picks the new level, writes it back and
// returns one result beat. Work runs on a single shared adder under a sequencer that steps
// each item through the read, span, hysteresis, multiply and check states, after a
// slot-remainder state when CHUNK_SLOTS is below 1024; the multiply steps grow with the
// active level count (1 to MAX_LEVELS). Item acceptance resumes while a finished result
// still waits to be taken; the next item then holds in its last cycle for as long as that
// result stays stalled. After reset the level store is cleared one entry per cycle,
// during which items are stalled; configuration writes are taken at any time, but
// should only be made while the block is idle.
`default_nettype none

module lod_select_hysteresis #(
  parameter int CHUNK_SLOTS = 1024,
  parameter int MAX_LEVELS  = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [4:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic [lsh_pkg::IDX_W-1:0]  chunk_index,
  input  wire logic [lsh_pkg::DIST_W-1:0] distance,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [lsh_pkg::IDX_W-1:0]       chunk_id,
  output logic [lsh_pkg::LVL_OUT_W-1:0]   detail_level,
  output logic                            level_changed
);
  import lsh_pkg::*;

  localparam int SLOT_W = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;

  cfg_t              cfg;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic              store_busy;
  logic [SLOT_W-1:0] rd_addr;
  logic [2:0]        rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [2:0]        wr_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.distance_scale      <= RST_DISTANCE_SCALE;
      cfg.world_size_x        <= '0;
      cfg.world_size_z        <= '0;
      cfg.level_count         <= RST_LEVEL_COUNT;
      cfg.hysteresis_fraction <= RST_HYST_FRACTION;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DISTANCE_SCALE: cfg.distance_scale      <= pwdata[DIST_W-1:0];
        REG_WORLD_SIZE_X:   cfg.world_size_x        <= pwdata[DIST_W-1:0];
        REG_WORLD_SIZE_Z:   cfg.world_size_z        <= pwdata[DIST_W-1:0];
        REG_LEVEL_COUNT:    cfg.level_count         <= pwdata[CNT_W-1:0];
        REG_HYST_FRACTION:  cfg.hysteresis_fraction <= pwdata[FRAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DISTANCE_SCALE: prdata = 32'(cfg.distance_scale);
      REG_WORLD_SIZE_X:   prdata = 32'(cfg.world_size_x);
      REG_WORLD_SIZE_Z:   prdata = 32'(cfg.world_size_z);
      REG_LEVEL_COUNT:    prdata = 32'(cfg.level_count);
      REG_HYST_FRACTION:  prdata = 32'(cfg.hysteresis_fraction);
      default:            prdata = '0;
    endcase
  end

  lsh_store #(.CHUNK_SLOTS(CHUNK_SLOTS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (store_busy)
  );

  lsh_seq #(
    .CHUNK_SLOTS (CHUNK_SLOTS),
    .MAX_LEVELS  (MAX_LEVELS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .store_busy    (store_busy),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .chunk_index   (chunk_index),
    .distance      (distance),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .chunk_id      (chunk_id),
    .detail_level  (detail_level),
    .level_changed (level_changed),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

endmodule

`default_nettype wire

/* sv/lsh_alu.sv */
`default_nettype none

// Shared adder of the sequencer; with an inverted operand and carry in it subtracts,
// and the carry out then tells a >= b.
module lsh_alu #(
  parameter int W = 30
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         cin,
  output logic [W-1:0]      sum,
  output logic              cout
);

  logic [W:0] full;

  assign full = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
  assign sum  = full[W-1:0];
  assign cout = full[W];

endmodule

`default_nettype wire

/* sv/lsh_store.sv */
`default_nettype none

module lsh_store #(
  parameter int CHUNK_SLOTS = 1024,
  localparam int SLOT_W = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output logic [2:0]             rd_data,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_addr,
  input  wire logic [2:0]        wr_data,
  output logic                   busy
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHUNK_SLOTS - 1);

  logic [2:0]        mem [CHUNK_SLOTS];
  logic              clearing;
  logic [SLOT_W-1:0] clr_addr;

  // After reset every entry is walked once and written to level zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_SLOT) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing;

endmodule

`default_nettype wire

/* sv/lsh_seq.sv */
`default_nettype none

module lsh_seq #(
  parameter int CHUNK_SLOTS = 1024,
  parameter int MAX_LEVELS  = 8,
  localparam int SLOT_W = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lsh_pkg::cfg_t             cfg,
  input  wire logic                      store_busy,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire logic [lsh_pkg::IDX_W-1:0]  chunk_index,
  input  wire logic [lsh_pkg::DIST_W-1:0] distance,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic [lsh_pkg::IDX_W-1:0]      chunk_id,
  output logic [lsh_pkg::LVL_OUT_W-1:0]  detail_level,
  output logic                           level_changed,
  output logic [SLOT_W-1:0]              rd_addr,
  input  wire logic [2:0]                rd_data,
  output logic                           wr_en,
  output logic [SLOT_W-1:0]              wr_addr,
  output logic [2:0]                     wr_data
);
  import lsh_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  // Multiples of the spacing up to MAX_LEVELS, plus the hysteresis.
  localparam int ACC_W = SPACE_W + LVL_W + 1;
  localparam bit NEED_MOD = (CHUNK_SLOTS < (1 << IDX_W));
  // A rounded-up reciprocal of the slot count gives the exact quotient for every index.
  localparam int MOD_SH = IDX_W + ((CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 0);
  localparam int MUL_W  = 2 * IDX_W + 1;
  localparam longint MOD_RECIP = ((longint'(1) << MOD_SH) + CHUNK_SLOTS - 1) / CHUNK_SLOTS;

  state_t state, state_next;

  logic [STEP_W-1:0]   step;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    rem;
  logic [DIST_W-1:0]   dist_q;
  logic [2:0]          stored;
  logic [LVL_W-1:0]    top;
  logic [LVL_W-1:0]    cur;
  logic [LVL_W-1:0]    desired;
  logic [LVL_W-1:0]    level;
  logic [SPACE_W-1:0]  spacing;
  logic [SPACE_W-1:0]  hyst;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    base;
  logic [ACC_W-1:0]    upper;

  logic [ACC_W-1:0]    alu_a;
  logic [ACC_W-1:0]    alu_b;
  logic                alu_cin;
  logic [ACC_W-1:0]    alu_sum;
  logic                alu_cout;

  logic                accept;
  logic                finish;
  logic [MUL_W-1:0]    mod_mul;
  logic [IDX_W-1:0]    mod_q;
  logic [IDX_W-1:0]    mod_prod;
  logic [DIST_W-1:0]   span;
  logic [SPACE_W-1:0]  span5;
  logic [SPACE_W-1:0]  floor_spacing;
  logic [SPACE_W-1:0]  spacing_new;
  logic [FRAC_W-1:0]   frac;
  logic [4:0]          n_lv;
  logic [LVL_W-1:0]    top_new;
  logic [3:0]          st4;
  logic [3:0]          tp4;
  logic [LVL_W-1:0]    cur_new;
  logic                move;
  logic [LVL_OUT_W-1:0] level3;

  lsh_alu #(.W(ACC_W)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .cin  (alu_cin),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  assign item_stall = (state != S_IDLE) || store_busy;
  assign accept     = item_valid && !item_stall;

  // Slot remainder: quotient by constant multiplies, then one subtraction on the adder.
  assign mod_mul  = MUL_W'(rem) * MUL_W'(MOD_RECIP);
  assign mod_q    = IDX_W'(mod_mul >> MOD_SH);
  assign mod_prod = IDX_W'(MUL_W'(mod_q) * MUL_W'(CHUNK_SLOTS));

  assign span  = (cfg.world_size_x > cfg.world_size_z) ? cfg.world_size_x : cfg.world_size_z;
  assign span5 = alu_sum[SPACE_W:1];
  assign floor_spacing = (cfg.distance_scale > MIN_SPACING) ?
                         SPACE_W'(cfg.distance_scale) : SPACE_W'(MIN_SPACING);
  assign spacing_new = (span5 > floor_spacing) ? span5 : floor_spacing;
  assign frac = (cfg.hysteresis_fraction > HYST_CAP) ? HYST_CAP : cfg.hysteresis_fraction;

  always_comb begin
    n_lv = (cfg.level_count == '0) ? 5'd1 : 5'(cfg.level_count);
    if (n_lv > 5'(MAX_LEVELS)) begin
      n_lv = 5'(MAX_LEVELS);
    end
    top_new = LVL_W'(n_lv - 5'd1);
  end

  assign st4     = 4'(rd_data);
  assign tp4     = 4'(top);
  assign cur_new = LVL_W'((st4 > tp4) ? tp4 : st4);

  // Upward moves test against the next boundary plus hysteresis; downward moves
  // test distance plus hysteresis against the current boundary.
  always_comb begin
    if (desired > cur) begin
      move = (ACC_W'(dist_q) >= alu_sum);
    end else if (desired < cur) begin
      move = (alu_sum <= base);
    end else begin
      move = 1'b0;
    end
  end

  assign level3 = LVL_OUT_W'(level);

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_cin    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = NEED_MOD ? S_MOD : S_READ;
        end
      end
      S_MOD: begin
        alu_a      = ACC_W'(rem);
        alu_b      = ~ACC_W'(mod_prod);
        alu_cin    = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_SPAN;
      end
      S_SPAN: begin
        alu_a      = ACC_W'(span);
        alu_b      = ACC_W'(span) << 2;
        state_next = S_HYST;
      end
      S_HYST: begin
        alu_a = ACC_W'(hyst);
        alu_b = frac[step[2:0]] ? ACC_W'(spacing) : '0;
        if (step == STEP_W'(HYST_STEPS - 1)) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        alu_a = acc;
        alu_b = ACC_W'(spacing);
        if (step == 5'(top) + 5'd1) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        alu_a      = (desired > cur) ? upper : ACC_W'(dist_q);
        alu_b      = ACC_W'(hyst);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!(result_valid && result_stall)) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  assign finish  = (state == S_DONE) && !(result_valid && result_stall);
  assign rd_addr = SLOT_W'(rem);
  assign wr_addr = SLOT_W'(rem);
  assign wr_data = level3;
  assign wr_en   = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_q  <= chunk_index;
          rem    <= chunk_index;
          dist_q <= distance;
          top    <= top_new;
        end
      end
      S_MOD: begin
        if (alu_cout) begin
          rem <= alu_sum[IDX_W-1:0];
        end
      end
      S_READ: begin
      end
      S_SPAN: begin
        stored  <= rd_data;
        cur     <= cur_new;
        spacing <= spacing_new;
        hyst    <= '0;
        step    <= '0;
      end
      S_HYST: begin
        // Right-shifting partial sums give floor(frac * spacing / 256) exactly.
        hyst <= alu_sum[SPACE_W:1];
        if (step == STEP_W'(HYST_STEPS - 1)) begin
          step    <= 5'd1;
          acc     <= '0;
          base    <= '0;
          upper   <= '0;
          desired <= '0;
        end else begin
          step <= step + 1'b1;
        end
      end
      S_MULT: begin
        acc <= alu_sum;
        if (step == 5'(cur)) begin
          base <= alu_sum;
        end
        if (step == 5'(cur) + 5'd1) begin
          upper <= alu_sum;
        end
        if ((ACC_W'(dist_q) >= alu_sum) && (step <= 5'(top))) begin
          desired <= LVL_W'(step);
        end
        step <= step + 1'b1;
      end
      S_CHK: begin
        level <= move ? desired : cur;
      end
      S_DONE: begin
        if (finish) begin
          chunk_id      <= idx_q;
          detail_level  <= level3;
          level_changed <= (level3 != stored);
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/lsh_checker.sv */
`default_nettype none

module lsh_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [9:0] chunk_id,
  input wire logic [2:0] detail_level,
  input wire logic       level_changed
);
`include "lod_select_hysteresis_macros.svh"

  // The store clear keeps items out right after reset, and nothing is pending.
  `LSH_ASSERT_AFTER_RESET(a_reset_quiet, !result_valid && item_stall)

  // One item at a time: an accepted beat makes the block busy in the next cycle.
  `LSH_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

  `LSH_ASSERT_NEXT(a_result_held, result_valid && result_stall,
                   result_valid && $stable(chunk_id) && $stable(detail_level) && $stable(level_changed))

endmodule

bind lod_select_hysteresis lsh_checker u_lsh_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsh_pkg::*;

  localparam int LEVEL_CAP      = 8;
  localparam int STORE_DEPTH    = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [IDX_W-1:0]     chunk;
    logic [LVL_OUT_W-1:0] level;
    logic                 changed;
  } lod_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  wire  [31:0]          prdata;
  wire                  pready;
  logic                 item_valid = 1'b0;
  wire                  item_stall;
  logic [IDX_W-1:0]     chunk_index = '0;
  logic [DIST_W-1:0]    distance = '0;
  wire                  result_valid;
  logic                 result_stall = 1'b0;
  wire  [IDX_W-1:0]     chunk_id;
  wire  [LVL_OUT_W-1:0] detail_level;
  wire                  level_changed;

  lod_select_hysteresis dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .chunk_index   (chunk_index),
    .distance      (distance),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .chunk_id      (chunk_id),
    .detail_level  (detail_level),
    .level_changed (level_changed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the block's configuration and per-chunk level store.
  cfg_t                 cfg_shadow = '{RST_DISTANCE_SCALE, 24'd0, 24'd0,
                                       RST_LEVEL_COUNT, RST_HYST_FRACTION};
  logic [LVL_OUT_W-1:0] level_state [STORE_DEPTH];
  lod_result_t          expected_levels [$];
  int                   beats_sent = 0;
  int                   beats_returned = 0;
  int                   mismatches = 0;
  int                   idle_cycles = 0;
  int                   cycle_count = 0;
  stall_mode_t          stall_mode = STALL_NONE;
  int                   stall_hold = 0;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) level_state[i] = '0;
  end

  function automatic longint unsigned active_levels();
    longint unsigned n;
    n = cfg_shadow.level_count;
    if (n == 0) n = 1;
    if (n > LEVEL_CAP) n = LEVEL_CAP;
    return n;
  endfunction

  function automatic longint unsigned level_spacing();
    longint unsigned span, sp;
    span = (cfg_shadow.world_size_x > cfg_shadow.world_size_z) ?
           cfg_shadow.world_size_x : cfg_shadow.world_size_z;
    sp = (cfg_shadow.distance_scale > MIN_SPACING) ? cfg_shadow.distance_scale : MIN_SPACING;
    if (((span * 5) >> 1) > sp) sp = (span * 5) >> 1;
    return sp;
  endfunction

  function automatic longint unsigned hysteresis_width();
    longint unsigned frac;
    frac = (cfg_shadow.hysteresis_fraction > HYST_CAP) ? HYST_CAP : cfg_shadow.hysteresis_fraction;
    return (frac * level_spacing()) >> 8;
  endfunction

  // Works out the level for one chunk and updates the shadow store.
  function automatic lod_result_t select_level(logic [IDX_W-1:0] idx,
                                               logic [DIST_W-1:0] dist_val);
    longint unsigned top, stored, cur, sp, hy, desired, lvl, base;
    lod_result_t     r;
    top     = active_levels() - 1;
    stored  = level_state[idx % STORE_DEPTH];
    cur     = (stored > top) ? top : stored;
    sp      = level_spacing();
    hy      = hysteresis_width();
    desired = dist_val / sp;
    if (desired > top) desired = top;
    lvl = cur;
    if (desired > cur) begin
      if (dist_val >= (cur + 1) * sp + hy) lvl = desired;
    end else if (desired < cur) begin
      base = cur * sp;
      if (base >= hy && dist_val <= base - hy) lvl = desired;
    end
    level_state[idx % STORE_DEPTH] = lvl[LVL_OUT_W-1:0];
    r.chunk   = idx;
    r.level   = lvl[LVL_OUT_W-1:0];
    r.changed = (lvl != stored);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Result checking comes first so that a beat accepted at this edge is
  // never compared against the prediction queued at the same edge.
  always @(posedge clk) begin : check_results
    lod_result_t got, want, pred;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        beats_returned++;
        got = {chunk_id, detail_level, level_changed};
        if (expected_levels.size() == 0) begin
          note_failure($sformatf("unexpected result beat: chunk %0d level %0d changed %0b",
                                 got.chunk, got.level, got.changed));
        end else begin
          want = expected_levels.pop_front();
          if (got !== want)
            note_failure($sformatf(
              "mismatch: expected chunk %0d level %0d changed %0b, got chunk %0d level %0d changed %0b",
              want.chunk, want.level, want.changed, got.chunk, got.level, got.changed));
        end
      end
      if (item_valid && !item_stall) begin
        pred = select_level(chunk_index, distance);
        expected_levels = {expected_levels, pred};
      end
    end
  end

  // The receiver switches to a new random stall behavior whenever its random hold runs out.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(50, 300);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:     result_stall <= 1'b0;
      STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: result_stall <= ((cycle_count % 7) < 3);
      default:        result_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAIL lod_select_hysteresis");
        $finish;
      end
    end
  end

  // Presents one beat and returns at the edge where it is taken. Valid stays
  // high so that a following call continues the burst.
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] dist_val);
    chunk_index <= idx;
    distance    <= dist_val;
    item_valid  <= 1'b1;
    do @(posedge clk); while (item_stall);
    beats_sent++;
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      item_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (beats_returned < beats_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DISTANCE_SCALE: cfg_shadow.distance_scale      = value[DIST_W-1:0];
      REG_WORLD_SIZE_X:   cfg_shadow.world_size_x        = value[DIST_W-1:0];
      REG_WORLD_SIZE_Z:   cfg_shadow.world_size_z        = value[DIST_W-1:0];
      REG_LEVEL_COUNT:    cfg_shadow.level_count         = value[CNT_W-1:0];
      REG_HYST_FRACTION:  cfg_shadow.hysteresis_fraction = value[FRAC_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [IDX_W-1:0] pick_chunk();
    case ($urandom_range(0, 9))
      0, 1:    return IDX_W'($urandom);
      2:       return IDX_W'(STORE_DEPTH - 1 - $urandom_range(0, 15));
      default: return IDX_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Most distances land near a level boundary or a hysteresis edge.
  function automatic logic [DIST_W-1:0] pick_distance();
    longint sp, hy, d;
    sp = level_spacing();
    hy = hysteresis_width();
    if ($urandom_range(0, 4) == 0) return DIST_W'($urandom);
    d = $urandom_range(0, active_levels()) * sp;
    case ($urandom_range(0, 2))
      0:       d = d + hy;
      1:       d = d - hy;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) d = d + $urandom_range(0, sp) - sp / 2;
    else d = d + $urandom_range(0, 6) - 3;
    if (d < 0) d = 0;
    if (d > DIST_MAX) d = DIST_MAX;
    return d[DIST_W-1:0];
  endfunction

  task automatic randomize_config();
    logic [DIST_W-1:0] ds;
    logic [DIST_W-1:0] wx;
    logic [DIST_W-1:0] wz;
    case ($urandom_range(0, 5))
      0:       ds = '0;
      1:       ds = DIST_MAX;
      2, 3:    ds = DIST_W'($urandom_range(20480, 600000));
      default: ds = DIST_W'($urandom);
    endcase
    wx = '0;
    wz = '0;
    case ($urandom_range(0, 9))
      0, 1:    begin
        wx = DIST_W'($urandom_range(0, 200000));
        wz = DIST_W'($urandom_range(0, 200000));
      end
      2:       begin wx = DIST_W'($urandom); wz = DIST_W'($urandom); end
      3:       wz = DIST_MAX;
      default: ;
    endcase
    write_reg(REG_DISTANCE_SCALE, ds);
    write_reg(REG_WORLD_SIZE_X, wx);
    write_reg(REG_WORLD_SIZE_Z, wz);
    write_reg(REG_LEVEL_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(2, 8));
    write_reg(REG_HYST_FRACTION, $urandom_range(0, 255));
  endtask

  // Reset configuration: spacing 80.0, hysteresis 8.125, four levels.
  task automatic test_default_config();
    send_beat(0, 0);
    send_beat(STORE_DEPTH - 1, DIST_MAX);
    send_beat(STORE_DEPTH - 1, 0);
    send_beat(5, 20480);
    send_beat(5, 20480 + 2080);
    send_beat(5, 20480);
    send_beat(5, 20480 - 2080);
    send_beat(6, 24'h800000);
    drain_results();
  endtask

  task automatic test_special_cases();
    // Oversized hysteresis and level count, scale below the floor.
    write_reg(REG_HYST_FRACTION, 255);
    write_reg(REG_LEVEL_COUNT, 15);
    write_reg(REG_DISTANCE_SCALE, 0);
    send_beat(7, DIST_MAX);
    send_beat(8, 3 * 20480 + 18400 - 1);
    drain_results();
    // The stored level of chunk 7 now lies above the range and gets clamped.
    write_reg(REG_LEVEL_COUNT, 2);
    send_beat(7, DIST_MAX);
    send_beat(9, DIST_MAX);
    drain_results();
    // A zero level count behaves as a single level.
    write_reg(REG_LEVEL_COUNT, 0);
    send_beat(STORE_DEPTH - 1, DIST_MAX);
    send_beat(7, 0);
    drain_results();
    // Spacing taken from the world extent.
    write_reg(REG_WORLD_SIZE_X, DIST_MAX);
    write_reg(REG_LEVEL_COUNT, LEVEL_CAP);
    write_reg(REG_HYST_FRACTION, 0);
    send_beat(10, DIST_MAX);
    send_beat(11, 0);
    drain_results();
    write_reg(REG_WORLD_SIZE_X, 0);
    write_reg(REG_WORLD_SIZE_Z, DIST_MAX);
    send_beat(12, DIST_MAX);
    drain_results();
    // A write to an unmapped register must leave the configuration alone.
    write_reg(REG_UNMAPPED, 32'h0000_0001);
    write_reg(REG_WORLD_SIZE_Z, 0);
    write_reg(REG_DISTANCE_SCALE, DIST_MAX);
    send_beat(13, DIST_MAX);
    send_beat(13, DIST_MAX - 1);
    send_beat(14, 20480);
    drain_results();
  endtask

  task automatic test_random_phases();
    int burst_left;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_DISTANCE_SCALE, 0);
          write_reg(REG_WORLD_SIZE_X, 0);
          write_reg(REG_WORLD_SIZE_Z, 0);
          write_reg(REG_LEVEL_COUNT, LEVEL_CAP);
          write_reg(REG_HYST_FRACTION, 0);
        end
        1: begin
          write_reg(REG_DISTANCE_SCALE, 300000);
          write_reg(REG_LEVEL_COUNT, 15);
          write_reg(REG_HYST_FRACTION, 255);
        end
        default: randomize_config();
      endcase
      burst_left = 0;
      for (int i = 0; i < 50; i++) begin
        if (burst_left == 0) begin
          if (phase != 2) idle_gap($urandom_range(0, 20));
          burst_left = $urandom_range(1, 16);
        end
        send_beat(pick_chunk(), pick_distance());
        burst_left--;
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_default_config();
    test_special_cases();
    test_random_phases();
    drain_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("PASS lod_select_hysteresis");
    end else begin
      $display("FAIL lod_select_hysteresis");
    end
    $finish;
  end

endmodule

/* lod_select_hysteresis.f */
+incdir+sv
sv/lsh_pkg.sv
sv/lsh_alu.sv
sv/lsh_store.sv
sv/lsh_seq.sv
sv/lod_select_hysteresis.sv
sv/lsh_checker.sv
sim/testbench.sv
